// ----- sv/dali_dec_pkg.sv -----
// Shared types and constants for the DALI input device forward-frame decoder.
package dali_dec_pkg;

	// Receive event kinds
	typedef enum logic [1:0] {
		EV_FRAME   = 2'd0,
		EV_TIMEOUT = 2'd1,
		EV_BADSEQ  = 2'd2,
		EV_UNUSED  = 2'd3
	} ev_kind_t;

	// Decoder outcome codes
	typedef enum logic [2:0] {
		OUT_IGNORE  = 3'd0,
		OUT_RESPOND = 3'd1,
		OUT_NACK    = 3'd2,
		OUT_REPEAT  = 3'd3,
		OUT_INVALID = 3'd4
	} outcome_t;

	// Address classes
	typedef enum logic [3:0] {
		AC_NONE       = 4'd0,
		AC_EVENT      = 4'd1,
		AC_SPECIAL    = 4'd2,
		AC_SPECIAL2   = 4'd3,
		AC_INSTANCE   = 4'd4,
		AC_INST_TYPE  = 4'd5,
		AC_FEAT_BCAST = 4'd6,
		AC_INST_BCAST = 4'd7,
		AC_FEAT_DEV   = 4'd8,
		AC_DEVICE     = 4'd9
	} aclass_t;

	// One decoded result item
	typedef struct packed {
		outcome_t   outcome;
		logic [7:0] reply;
		aclass_t    aclass;
	} result_t;

	localparam int unsigned FRAME_W   = 25;
	localparam int unsigned LEN_W     = 6;
	localparam int unsigned ADDR_W    = 7;
	localparam logic [LEN_W-1:0] LEN_STD    = 6'd24;
	localparam logic [LEN_W-1:0] LEN_LONG   = 6'd25;
	localparam logic [ADDR_W-1:0] ADDR_NONE = 7'h40;

	// Address byte codes
	localparam logic [7:0] B0_SPECIAL  = 8'hC1;
	localparam logic [7:0] B0_TOP_MASK = 8'hC0;
	localparam logic [6:0] DEV_UNADDR  = 7'h7E;
	localparam logic [6:0] DEV_BCAST   = 7'h7F;

	// Instance byte codes
	localparam logic [2:0] FL_INSTANCE = 3'd0;
	localparam logic [2:0] FL_TYPE     = 3'd6;
	localparam logic [2:0] FL_GROUP    = 3'd7;
	localparam logic [7:0] B1_FEAT_BCAST = 8'hFD;
	localparam logic [7:0] B1_INST_BCAST = 8'hFF;
	localparam logic [7:0] B1_FEAT_DEV   = 8'hFC;
	localparam logic [7:0] B1_DEVICE     = 8'hFE;

	// Opcode byte codes
	localparam logic [7:0] OP_REPEAT_MAX = 8'h21;
	localparam logic [7:0] OP_QUERY_ERR0 = 8'h31;
	localparam logic [7:0] OP_QUERY_ERR1 = 8'h32;
	localparam logic [7:0] OP_QUERY_TYPE = 8'h80;
	localparam logic [7:0] OP_QUIET_ON   = 8'h1D;
	localparam logic [7:0] OP_QUIET_OFF  = 8'h1E;

	// Special command codes that load the DTRs
	localparam logic [7:0] SP_DTR0_A = 8'h20;
	localparam logic [7:0] SP_DTR0_B = 8'h21;
	localparam logic [7:0] SP_DTR0_C = 8'h30;
	localparam logic [7:0] SP_DTR1   = 8'h31;
	localparam logic [7:0] SP_DTR2   = 8'h32;

	localparam logic [7:0] REPLY_TYPE = 8'h01;

endpackage

// ----- sv/dali_dec_classify.sv -----
// Address classifier: maps the address and instance bytes to an address class.
module dali_dec_classify #(
	parameter int unsigned INSTANCE_COUNT = 5
) (
	input  logic [7:0]                          b0,
	input  logic [7:0]                          b1,
	input  logic [dali_dec_pkg::ADDR_W-1:0]     own_addr,
	output dali_dec_pkg::aclass_t               aclass
);
	import dali_dec_pkg::*;

	logic [6:0] dev;
	logic [2:0] flags;
	logic [4:0] sel;
	logic       addr_hit;

	assign dev   = b0[7:1];
	assign flags = b1[7:5];
	assign sel   = b1[4:0];

	// Device address match: unaddressed, broadcast or own short address
	always_comb begin
		if (dev == DEV_UNADDR) begin
			addr_hit = (own_addr == ADDR_NONE);
		end else if (dev == DEV_BCAST) begin
			addr_hit = 1'b1;
		end else begin
			addr_hit = (own_addr == dev);
		end
	end

	// Class selection
	always_comb begin
		aclass = AC_NONE;
		if (!b0[0]) begin
			aclass = AC_EVENT;
		end else if ((b0 & B0_TOP_MASK) != 8'h00) begin
			aclass = (b0 == B0_SPECIAL) ? AC_SPECIAL : AC_SPECIAL2;
		end else if (addr_hit) begin
			if (flags == FL_INSTANCE) begin
				aclass = ({1'b0, sel} < 6'(INSTANCE_COUNT)) ? AC_INSTANCE : AC_NONE;
			end else if (flags == FL_TYPE) begin
				aclass = (sel == 5'd1) ? AC_INST_TYPE : AC_NONE;
			end else if (flags == FL_GROUP) begin
				case (b1)
					B1_FEAT_BCAST: aclass = AC_FEAT_BCAST;
					B1_INST_BCAST: aclass = AC_INST_BCAST;
					B1_FEAT_DEV:   aclass = AC_FEAT_DEV;
					B1_DEVICE:     aclass = AC_DEVICE;
					default:       aclass = AC_NONE;
				endcase
			end
		end
	end

endmodule

// ----- sv/dali_dec_ctrl.sv -----
// Frame decode and decoder state: repeat check, quiescent mode, DTR loads, replies.
module dali_dec_ctrl #(
	parameter int unsigned INSTANCE_COUNT = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  dali_dec_pkg::ev_kind_t              kind,
	input  logic [dali_dec_pkg::FRAME_W-1:0]    frame_data,
	input  logic [dali_dec_pkg::LEN_W-1:0]      frame_length,
	input  logic [dali_dec_pkg::ADDR_W-1:0]     own_addr,
	output dali_dec_pkg::result_t               res
);
	import dali_dec_pkg::*;

	// Decoder state
	logic               pend_q;
	logic [FRAME_W-1:0] last_frame_q;
	logic [LEN_W-1:0]   last_len_q;
	logic               quiet_q;
	logic [7:0]         dtr_q [3];

	logic [FRAME_W-1:0] data_fix;
	logic [LEN_W-1:0]   len_fix;
	logic [7:0]         b0, b1, b2;
	aclass_t            cls;
	logic               same, decode, accept, quiet_block;

	logic               pend_d, quiet_d;
	logic [FRAME_W-1:0] last_frame_d;
	logic [LEN_W-1:0]   last_len_d;
	logic [1:0]         dtr_sel;
	logic               dtr_we;

	// 25-bit repair: drop bit 8
	always_comb begin
		if (frame_length == LEN_LONG) begin
			data_fix = {1'b0, frame_data[24:9], frame_data[7:0]};
			len_fix  = LEN_STD;
		end else begin
			data_fix = frame_data;
			len_fix  = frame_length;
		end
	end

	assign b0 = data_fix[23:16];
	assign b1 = data_fix[15:8];
	assign b2 = data_fix[7:0];

	dali_dec_classify #(
		.INSTANCE_COUNT(INSTANCE_COUNT)
	) u_classify (
		.b0       (b0),
		.b1       (b1),
		.own_addr (own_addr),
		.aclass   (cls)
	);

	assign same        = (last_frame_q == data_fix) && (last_len_q == len_fix);
	// a pending repeat drops any frame that is not an exact copy
	assign decode      = (!pend_q || same) && (len_fix == LEN_STD);
	assign quiet_block = quiet_q && !((b1 == B1_DEVICE) && (b2 == OP_QUIET_OFF));
	assign accept      = decode && (cls != AC_NONE) && !quiet_block;

	// Result and next state
	always_comb begin
		res.outcome  = OUT_IGNORE;
		res.reply    = 8'h00;
		res.aclass   = AC_NONE;
		pend_d       = pend_q;
		quiet_d      = quiet_q;
		last_frame_d = last_frame_q;
		last_len_d   = last_len_q;
		dtr_we       = 1'b0;
		dtr_sel      = 2'd0;
		case (kind)
			EV_FRAME: begin
				last_frame_d = data_fix;
				last_len_d   = len_fix;
				if (decode) begin
					res.aclass = cls;
				end
				if (accept) begin
					if (cls == AC_SPECIAL) begin
						if (b1 == SP_DTR0_A || b1 == SP_DTR0_B || b1 == SP_DTR0_C) begin
							dtr_we  = 1'b1;
							dtr_sel = 2'd0;
						end else if (b1 == SP_DTR1) begin
							dtr_we  = 1'b1;
							dtr_sel = 2'd1;
						end else if (b1 == SP_DTR2) begin
							dtr_we  = 1'b1;
							dtr_sel = 2'd2;
						end
					end else if (cls != AC_SPECIAL2 && cls != AC_EVENT) begin
						if (b2 <= OP_REPEAT_MAX && !pend_q) begin
							res.outcome = OUT_REPEAT;
						end else if (b2 == OP_QUERY_ERR0 || b2 == OP_QUERY_ERR1) begin
							res.outcome = OUT_RESPOND;
						end else if (b2 == OP_QUERY_TYPE) begin
							res.outcome = OUT_RESPOND;
							res.reply   = REPLY_TYPE;
						end else if (b2 == OP_QUIET_ON) begin
							quiet_d     = 1'b1;
							res.outcome = OUT_NACK;
						end else if (b2 == OP_QUIET_OFF) begin
							quiet_d     = 1'b0;
							res.outcome = OUT_NACK;
						end
					end
				end
				pend_d = (res.outcome == OUT_REPEAT);
			end
			EV_TIMEOUT: begin
				res.outcome = OUT_INVALID;
				pend_d      = 1'b0;
			end
			EV_BADSEQ: begin
				res.outcome  = OUT_INVALID;
				pend_d       = 1'b0;
				last_frame_d = '0;
				last_len_d   = '0;
			end
			default: begin
				res.outcome = OUT_IGNORE;
			end
		endcase
	end

	// State registers, updated once per decoded item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= 1'b0;
			quiet_q      <= 1'b0;
			last_frame_q <= '0;
			last_len_q   <= '0;
			dtr_q[0]     <= 8'h00;
			dtr_q[1]     <= 8'h00;
			dtr_q[2]     <= 8'h00;
		end else if (step) begin
			pend_q       <= pend_d;
			quiet_q      <= quiet_d;
			last_frame_q <= last_frame_d;
			last_len_q   <= last_len_d;
			if (dtr_we) begin
				dtr_q[dtr_sel] <= b2;
			end
		end
	end

endmodule

// ----- sv/dali_input_device_frame_decoder.sv -----
// Top level of the DALI input device forward-frame decoder.
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid/in_ready, cmd, frame_data, frame_length | to block
//  out     | out_valid/out_ready, outcome, reply_byte,        | from block
//          | address_class                                  |
//  cfg     | cfg_valid/cfg_ready, cfg_data (short address)    | to block
//
// One item per cycle sustained while the output is not stalled; an accepted item lands in
// the input register, and its result is valid once decode loads the result register.
// Decoder state updates at the edge that loads the result register, so the
// next item already sees it. cfg_ready is always high.
// Reset clears valids, decoder state, and sets the short address to none (64).
// A stalled output holds the result register and the input register; in_ready
// drops only when both are full and out_ready is low.
module dali_input_device_frame_decoder #(
	parameter int unsigned INSTANCE_COUNT = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [24:0] frame_data,
	input  logic [5:0]  frame_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  outcome,
	output logic [7:0]  reply_byte,
	output logic [3:0]  address_class,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);
	import dali_dec_pkg::*;

	logic [ADDR_W-1:0]  own_addr_q;
	logic               valid_s1;
	ev_kind_t           kind_s1;
	logic [FRAME_W-1:0] data_s1;
	logic [LEN_W-1:0]   len_s1;
	logic               out_valid_q;
	result_t            res_q;
	result_t            res;
	logic               advance;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= ADDR_NONE;
		end else if (cfg_valid) begin
			own_addr_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= ev_kind_t'(cmd);
			data_s1 <= frame_data;
			len_s1  <= frame_length;
		end
	end

	dali_dec_ctrl #(
		.INSTANCE_COUNT(INSTANCE_COUNT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.kind         (kind_s1),
		.frame_data   (data_s1),
		.frame_length (len_s1),
		.own_addr     (own_addr_q),
		.res          (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign outcome       = res_q.outcome;
	assign reply_byte    = res_q.reply;
	assign address_class = res_q.aclass;

endmodule

// ----- tb/dali_input_device_frame_decoder_tb.sv -----
// Self-checking testbench for the DALI input device forward-frame decoder.
`timescale 1ns / 100ps

module dali_input_device_frame_decoder_tb;
	import dali_dec_pkg::*;

	localparam int unsigned INST_COUNT  = 5;
	localparam int          STALL_LIMIT = 2000;
	localparam int          HOLD_CYCLES = 120;
	localparam int          MAX_PRINTS  = 20;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd          = EV_FRAME;
	logic [24:0] frame_data   = '0;
	logic [5:0]  frame_length = '0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [2:0]  outcome;
	logic [7:0]  reply_byte;
	logic [3:0]  address_class;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data     = '0;

	dali_input_device_frame_decoder #(
		.INSTANCE_COUNT(INST_COUNT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.frame_data   (frame_data),
		.frame_length (frame_length),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.outcome      (outcome),
		.reply_byte   (reply_byte),
		.address_class(address_class),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decoder shadow state
	logic [6:0]  own_addr = ADDR_NONE;
	outcome_t    prev_outcome = OUT_IGNORE;
	logic [24:0] prev_frame = '0;
	logic [5:0]  prev_len = '0;
	logic        quiet_mode = 1'b0;
	logic [7:0]  dtr_shadow [3] = '{8'h00, 8'h00, 8'h00};

	result_t pending_results [$];
	int      err_count       = 0;
	int      items_sent      = 0;
	int      results_checked = 0;
	int      addr_settings   = 0;

	// Sender and receiver pacing
	int   tx_burst_left = 0;
	bit   tx_gaps_on    = 1'b0;
	logic rx_pattern_on = 1'b0;
	logic hold_on       = 1'b0;

	// Address class of a 24-bit frame from its first two bytes
	function automatic aclass_t classify_addr(logic [7:0] b0, logic [7:0] b1);
		logic [6:0] dev;
		logic [2:0] flags;
		logic [4:0] sel;
		if (!b0[0])
			return AC_EVENT;
		if ((b0 & B0_TOP_MASK) != 8'h00)
			return (b0 == B0_SPECIAL) ? AC_SPECIAL : AC_SPECIAL2;
		dev = b0[7:1];
		if (dev == DEV_UNADDR) begin
			if (own_addr != ADDR_NONE)
				return AC_NONE;
		end else if (dev != DEV_BCAST) begin
			if (own_addr != dev)
				return AC_NONE;
		end
		flags = b1[7:5];
		sel = b1[4:0];
		if (flags == FL_INSTANCE)
			return (sel < INST_COUNT) ? AC_INSTANCE : AC_NONE;
		if (flags == FL_TYPE)
			return (sel == 5'd1) ? AC_INST_TYPE : AC_NONE;
		if (flags != FL_GROUP)
			return AC_NONE;
		if (b1 == B1_FEAT_BCAST) return AC_FEAT_BCAST;
		if (b1 == B1_INST_BCAST) return AC_INST_BCAST;
		if (b1 == B1_FEAT_DEV) return AC_FEAT_DEV;
		if (b1 == B1_DEVICE) return AC_DEVICE;
		return AC_NONE;
	endfunction

	// Expected result of one receive event; advances the shadow state
	function automatic result_t decode_frame_event(ev_kind_t k, logic [24:0] d, logic [5:0] l);
		result_t     r;
		logic        second;
		logic        skip;
		logic [24:0] fd;
		logic [5:0]  fl;
		logic [7:0]  b0, b1, b2;
		r.outcome = OUT_IGNORE;
		r.reply = 8'h00;
		r.aclass = AC_NONE;
		fd = d;
		fl = l;
		second = 1'b0;
		skip = 1'b0;
		case (k)
			EV_FRAME: begin
				// 25-bit frames lose bit 8
				if (fl == LEN_LONG) begin
					fd = ((fd >> 1) & 25'hFFFF00) | (fd & 25'h0000FF);
					fl = LEN_STD;
				end
				if (prev_outcome == OUT_REPEAT) begin
					if (prev_frame == fd && prev_len == fl)
						second = 1'b1;
					else
						skip = 1'b1;
				end
				prev_frame = fd;
				prev_len = fl;
				if (!skip && fl == LEN_STD) begin
					b0 = fd[23:16];
					b1 = fd[15:8];
					b2 = fd[7:0];
					r.aclass = classify_addr(b0, b1);
					if (r.aclass != AC_NONE &&
					    !(quiet_mode && !(b1 == B1_DEVICE && b2 == OP_QUIET_OFF))) begin
						if (r.aclass == AC_SPECIAL) begin
							if (b1 == SP_DTR0_A || b1 == SP_DTR0_B || b1 == SP_DTR0_C)
								dtr_shadow[0] = b2;
							else if (b1 == SP_DTR1)
								dtr_shadow[1] = b2;
							else if (b1 == SP_DTR2)
								dtr_shadow[2] = b2;
						end else if (r.aclass != AC_SPECIAL2 && r.aclass != AC_EVENT) begin
							if (b2 <= OP_REPEAT_MAX && !second) begin
								r.outcome = OUT_REPEAT;
							end else if (b2 == OP_QUERY_ERR0 || b2 == OP_QUERY_ERR1) begin
								r.outcome = OUT_RESPOND;
							end else if (b2 == OP_QUERY_TYPE) begin
								r.outcome = OUT_RESPOND;
								r.reply = REPLY_TYPE;
							end else if (b2 == OP_QUIET_ON) begin
								quiet_mode = 1'b1;
								r.outcome = OUT_NACK;
							end else if (b2 == OP_QUIET_OFF) begin
								quiet_mode = 1'b0;
								r.outcome = OUT_NACK;
							end
						end
					end
				end
				prev_outcome = r.outcome;
			end
			EV_TIMEOUT: begin
				r.outcome = OUT_INVALID;
				prev_outcome = OUT_INVALID;
			end
			EV_BADSEQ: begin
				r.outcome = OUT_INVALID;
				prev_outcome = OUT_INVALID;
				prev_frame = '0;
				prev_len = '0;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("ERROR @%0t: %s got %0d, expected %0d", $time, what, got, want);
	endtask

	// Result checker and receiver pacing
	always @(posedge clk) begin
		result_t want;
		int      rx_left;
		bit      rx_stall;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending, outcome", outcome, -1);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (outcome !== want.outcome)
					report_mismatch("outcome", outcome, want.outcome);
				if (reply_byte !== want.reply)
					report_mismatch("reply_byte", reply_byte, want.reply);
				if (address_class !== want.aclass)
					report_mismatch("address_class", address_class, want.aclass);
			end
		end
		// alternating ready and stall runs of random length
		if (hold_on) begin
			out_ready <= 1'b0;
		end else if (!rx_pattern_on) begin
			out_ready <= 1'b1;
		end else begin
			if (rx_left <= 0) begin
				rx_stall = !rx_stall;
				rx_left = rx_stall ? $urandom_range(1, 6) : $urandom_range(1, 12);
			end
			rx_left--;
			out_ready <= !rx_stall;
		end
	end

	// Watchdog on cycles without any handshake
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one item and wait for it to be taken; with gaps on, bursts end in random gaps
	task automatic send_item(input ev_kind_t k, input logic [24:0] d, input logic [5:0] l);
		int gap;
		in_valid <= 1'b1;
		cmd <= k;
		frame_data <= d;
		frame_length <= l;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(decode_frame_event(k, d, l));
		items_sent++;
		if (tx_burst_left > 0) begin
			tx_burst_left--;
		end else if (tx_gaps_on) begin
			tx_burst_left = $urandom_range(0, 15);
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
		send_item(EV_FRAME, {1'b0, b0, b1, b2}, LEN_STD);
	endtask

	// Stop offering and wait for every pending result
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_short_address(input logic [6:0] a);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= a;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		own_addr = a;
		addr_settings++;
	endtask

	task automatic hold_receiver(input int n);
		fork
			begin
				hold_on <= 1'b1;
				repeat (n) @(posedge clk);
				hold_on <= 1'b0;
			end
		join_none
	endtask

	// Random byte pickers, weighted toward the decoded codes
	function automatic logic [7:0] pick_addr_byte();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return (own_addr < 7'd32) ? {own_addr, 1'b1}
			                                      : {2'b00, 5'($urandom), 1'b1};
			4: return {2'b00, 5'($urandom), 1'b1};
			5: return B0_SPECIAL;
			6: return 8'hFF;
			7: return 8'hFD;
			8: return {7'($urandom), 1'b0};
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_instance_byte(input logic [7:0] b0);
		if (b0 == B0_SPECIAL) begin
			case ($urandom_range(0, 5))
				0: return SP_DTR0_A;
				1: return SP_DTR0_B;
				2: return SP_DTR0_C;
				3: return SP_DTR1;
				4: return SP_DTR2;
				default: return 8'($urandom);
			endcase
		end
		case ($urandom_range(0, 10))
			0: return {FL_INSTANCE, 5'($urandom_range(0, INST_COUNT + 2))};
			1: return {FL_TYPE, 5'd1};
			2: return {FL_TYPE, 5'($urandom)};
			3: return B1_FEAT_BCAST;
			4: return B1_INST_BCAST;
			5: return B1_FEAT_DEV;
			6, 7, 8: return B1_DEVICE;
			9: return {FL_GROUP, 5'($urandom)};
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_opcode_byte();
		case ($urandom_range(0, 10))
			0: return 8'h00;
			1: return 8'($urandom_range(0, OP_REPEAT_MAX));
			2: return OP_REPEAT_MAX;
			3: return OP_REPEAT_MAX + 8'd1;
			4: return OP_QUIET_ON;
			5: return OP_QUIET_OFF;
			6: return OP_QUERY_ERR0;
			7: return OP_QUERY_ERR1;
			8: return OP_QUERY_TYPE;
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly well-formed frames and repeat pairs, some broken pairs and noise
	task automatic send_random_item();
		logic [7:0]  b0, b1, b2;
		logic [24:0] d24;
		int          pick;
		pick = $urandom_range(0, 99);
		b0 = pick_addr_byte();
		b1 = pick_instance_byte(b0);
		b2 = pick_opcode_byte();
		d24 = {1'b0, b0, b1, b2};
		if (pick < 55) begin
			send_item(EV_FRAME, d24, LEN_STD);
			if (b2 <= OP_REPEAT_MAX && $urandom_range(0, 3) != 0)
				send_item(EV_FRAME, d24, LEN_STD);
		end else if (pick < 70) begin
			// long form with a random stuffed bit 8
			send_item(EV_FRAME, {d24[23:8], 1'($urandom), d24[7:0]}, LEN_LONG);
			if ($urandom_range(0, 1))
				send_item(EV_FRAME, d24, LEN_STD);
		end else if (pick < 78) begin
			send_item(ev_kind_t'(2'($urandom_range(1, 3))), 25'($urandom), 6'($urandom));
		end else if (pick < 88) begin
			// repeat spoiled by a single flipped bit, bit 24 included
			send_item(EV_FRAME, d24, LEN_STD);
			send_item(EV_FRAME, d24 ^ (25'd1 << $urandom_range(0, 24)), LEN_STD);
		end else begin
			send_item(ev_kind_t'(2'($urandom)), 25'($urandom), 6'($urandom));
		end
	endtask

	// Event kinds, field extremes and non-device address bytes
	task automatic test_event_kinds();
		send_item(EV_TIMEOUT, 25'h0000000, 6'd0);
		send_item(EV_BADSEQ, 25'h1FFFFFF, 6'd63);
		send_item(EV_UNUSED, 25'h0AAAAAA, 6'd21);
		send_item(EV_FRAME, 25'h1FFFFFF, LEN_STD);
		send_item(EV_FRAME, 25'h0000000, 6'd0);
		send_item(EV_FRAME, 25'h1FFFFFF, LEN_LONG);
		send_frame(8'h00, 8'hFE, 8'h80);
		send_frame(B0_SPECIAL, SP_DTR0_C, 8'hAA);
		send_frame(B0_SPECIAL, SP_DTR1, 8'h55);
		send_frame(B0_SPECIAL, SP_DTR2, 8'h0F);
		send_frame(B0_SPECIAL, 8'h40, 8'h01);
		drain_results();
	endtask

	// Instance byte decoding and queries at a short address
	task automatic test_address_classes();
		write_short_address(7'd5);
		send_frame(8'h0B, B1_DEVICE, OP_QUERY_TYPE);
		send_frame(8'h0B, 8'h03, OP_QUERY_ERR0);
		send_frame(8'h0B, 8'h05, OP_QUERY_ERR1);
		send_frame(8'h0B, 8'hC1, OP_QUERY_TYPE);
		send_frame(8'h0B, B1_FEAT_BCAST, OP_QUERY_ERR0);
		send_frame(8'h0B, B1_INST_BCAST, OP_QUERY_TYPE);
		send_frame(8'h0B, B1_FEAT_DEV, OP_QUERY_ERR1);
		send_frame(8'h0B, 8'hE0, OP_QUERY_TYPE);
		send_frame(8'h0D, B1_DEVICE, OP_QUERY_TYPE);
		drain_results();
	endtask

	// Twice-sent commands: completed, spoiled, cancelled, mixed frame lengths
	task automatic test_repeat_rules();
		send_frame(8'h0B, B1_DEVICE, 8'h10);
		send_frame(8'h0B, B1_DEVICE, 8'h10);
		send_frame(8'h0B, B1_DEVICE, 8'h00);
		send_item(EV_FRAME, {1'b1, 8'h0B, B1_DEVICE, 8'h00}, LEN_STD);
		send_frame(8'h0B, B1_DEVICE, OP_REPEAT_MAX);
		send_item(EV_TIMEOUT, 25'h0, 6'd0);
		send_frame(8'h0B, B1_DEVICE, OP_REPEAT_MAX);
		send_item(EV_BADSEQ, 25'h0, 6'd0);
		send_item(EV_FRAME, {8'h0B, B1_DEVICE, 1'b1, 8'h00}, LEN_LONG);
		send_frame(8'h0B, B1_DEVICE, 8'h00);
		drain_results();
	endtask

	// Quiescent mode entry, a masked query, and exit
	task automatic test_quiescent_mode();
		send_frame(8'h0B, B1_DEVICE, OP_QUIET_ON);
		send_frame(8'h0B, B1_DEVICE, OP_QUIET_ON);
		send_frame(8'h0B, B1_DEVICE, OP_QUERY_TYPE);
		send_frame(8'h0B, B1_DEVICE, OP_QUIET_OFF);
		send_frame(8'h0B, B1_DEVICE, OP_QUIET_OFF);
		drain_results();
	endtask

	task automatic test_random_traffic(input logic [6:0] a, input int n, input bit paced);
		int goal;
		write_short_address(a);
		tx_gaps_on = paced;
		rx_pattern_on <= paced;
		goal = items_sent + n;
		while (items_sent < goal)
			send_random_item();
		drain_results();
	endtask

	// Receiver holds off while the sender keeps offering, filling the block
	task automatic test_output_stall();
		int goal;
		write_short_address(7'd31);
		tx_gaps_on = 1'b0;
		rx_pattern_on <= 1'b0;
		hold_receiver(HOLD_CYCLES);
		goal = items_sent + 30;
		while (items_sent < goal)
			send_random_item();
		drain_results();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_event_kinds();
		test_address_classes();
		test_repeat_rules();
		test_quiescent_mode();
		test_random_traffic(7'd0, 60, 1'b0);
		test_random_traffic(7'd31, 60, 1'b1);
		test_random_traffic(ADDR_NONE, 50, 1'b1);
		test_random_traffic(7'd127, 50, 1'b1);
		test_random_traffic(7'($urandom_range(0, 31)), 60, 1'b1);
		test_random_traffic(7'($urandom), 40, 1'b1);
		test_output_stall();
		repeat (10) @(posedge clk);
		$display("Sent %0d items, checked %0d results over %0d short address settings,",
		         items_sent, results_checked, addr_settings);
		$display("with paced and gapless traffic and a %0d-cycle output hold-off.",
		         HOLD_CYCLES);
		if (err_count == 0 && pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- files.f -----
sv/dali_dec_pkg.sv
sv/dali_dec_classify.sv
sv/dali_dec_ctrl.sv
sv/dali_input_device_frame_decoder.sv
tb/dali_input_device_frame_decoder_tb.sv
